/* design/uvsg_pkg.sv */
`timescale 1ns / 1ps

package uvsg_pkg;

  localparam int MAX_SEGMENTS = 255;
  localparam int FRAC_BITS    = 14;
  localparam int TEX_FRAC     = 15;
  localparam logic [7:0] SEGMENTS_RESET = 8'd48;

  // pi/2 in Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam int DIV_STEPS     = 32;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

  localparam int NTERMS = 5;

  // series divisors k(k+1) split into 2^shift * j, j odd; floor(x/j) = (x*m) >> (32+l)
  // with m = ceil(2^(32+l)/j), exact for x < 2^32
  localparam int TERM_SHIFT_ODD [NTERMS] = '{1, 2, 1, 3, 1};
  localparam int TERM_L_ODD     [NTERMS] = '{2, 3, 5, 4, 6};
  localparam logic [32:0] TERM_M_ODD [NTERMS] = '{
    33'(((65'd1 << 34) + 65'd2) / 65'd3),
    33'(((65'd1 << 35) + 65'd4) / 65'd5),
    33'(((65'd1 << 37) + 65'd20) / 65'd21),
    33'(((65'd1 << 36) + 65'd8) / 65'd9),
    33'(((65'd1 << 38) + 65'd54) / 65'd55)
  };

  localparam int TERM_SHIFT_EVEN [NTERMS] = '{1, 2, 1, 3, 1};
  localparam int TERM_L_EVEN     [NTERMS] = '{0, 2, 4, 3, 6};
  localparam logic [32:0] TERM_M_EVEN [NTERMS] = '{
    33'(65'd1 << 32),
    33'(((65'd1 << 34) + 65'd2) / 65'd3),
    33'(((65'd1 << 36) + 65'd14) / 65'd15),
    33'(((65'd1 << 35) + 65'd6) / 65'd7),
    33'(((65'd1 << 38) + 65'd44) / 65'd45)
  };

  typedef struct packed {
    logic        oor;
    logic        pole;
    logic [15:0] vidx;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } side_t;

  typedef struct packed {
    logic [7:0]  d;
    logic [8:0]  rem_a;
    logic [31:0] q_a;
    logic [7:0]  rem_b;
    logic [31:0] q_b;
    logic [7:0]  rem_u;
    logic [15:0] q_u;
    logic [7:0]  rem_v;
    logic [15:0] q_v;
  } div_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic [30:0]        t;
    logic [31:0]        t2;
    logic [31:0]        term_o;
    logic [31:0]        term_e;
    logic [32:0]        pre_o;
    logic [32:0]        pre_e;
    logic signed [33:0] acc_o;
    logic signed [33:0] acc_e;
  } ang_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_z;
    logic [15:0]        vertex_index;
    logic               out_of_range;
  } res_t;

endpackage

/* design/uvsg_if.sv */
`timescale 1ns / 1ps

interface uvsg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] row;
  logic [7:0] col;

  modport source (output valid, output row, output col, input ready);
  modport sink (input valid, input row, input col, output ready);
endinterface

interface uvsg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic signed [15:0] tangent_x;
  logic signed [15:0] tangent_z;
  logic [15:0]        vertex_index;
  logic               out_of_range;

  modport source (output valid, output pos_x, output pos_y, output pos_z, output tex_u,
                  output tex_v, output tangent_x, output tangent_z, output vertex_index,
                  output out_of_range, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, input tex_u,
                input tex_v, input tangent_x, input tangent_z, input vertex_index,
                input out_of_range, output ready);
endinterface

/* design/uv_sphere_vertex_generator.sv */
`timescale 1ns / 1ps
// throughput: one request per cycle, held while the output stalls;
// 34 pipeline stages plus an output register
// depth is set by the two-bit-per-stage divider chain (16 stages) and the
// series evaluation (one multiply stage and one reciprocal stage per term)
// reset (rst, synchronous): clears all valid bits, segments returns to 48

module uv_sphere_vertex_generator (
  input  logic       clk,
  input  logic       rst,
  input  logic       seg_we,
  input  logic [7:0] seg_wdata,
  uvsg_in_if.sink    in_ch,
  uvsg_out_if.source out_ch
);
  import uvsg_pkg::*;

  localparam int ST_T1 = DIV_STAGES + 2;
  localparam int ST_T2 = ST_T1 + 1;
  localparam int ST_M1 = ST_T2 + 1;
  localparam int ST_F  = ST_M1 + 2 * NTERMS;
  localparam int ST_Q  = ST_F + 1;
  localparam int ST_O1 = ST_Q + 1;
  localparam int ST_O2 = ST_O1 + 1;
  localparam int NSTG  = ST_O2 + 1;
  localparam int RSH   = 60 - FRAC_BITS;
  localparam logic [63:0] ONE_OUT = 64'd1 << FRAC_BITS;
  localparam logic [15:0] POLE_TZ = 16'(64'd0 - ONE_OUT);

  logic [7:0] segments;
  logic [7:0] seg_eff;
  logic       en;
  logic       vld [NSTG];
  logic       out_vld;
  res_t       res_next;
  res_t       res_q;
  res_t       out_q;

  logic [7:0] r0_row, r0_col, r0_seg;
  side_t      side_q [1:ST_O1];
  div_t       dv [0:DIV_STAGES];
  ang_t       ang [ST_T1:ST_F-1][2];
  logic [1:0]  f_quad [2];
  logic [30:0] f_s [2];
  logic [30:0] f_c [2];
  logic signed [31:0] q_s [2];
  logic signed [31:0] q_c [2];
  logic [61:0] o1_px, o1_pz, o1_py;
  logic        o1_nx, o1_nz, o1_ny;

  function automatic div_t div_step(input div_t v, input int k);
    div_t        o;
    logic [31:0] low_a;
    logic [31:0] low_b;
    logic [14:0] low_t;
    logic [9:0]  ra;
    logic [9:0]  da;
    logic [8:0]  rb;
    logic [8:0]  ru;
    logic [8:0]  rv;
    logic [8:0]  db;
    int          kt;
    o     = v;
    low_a = {24'd0, v.d};
    low_b = {25'd0, v.d[7:1]};
    low_t = {8'd0, v.d[7:1]};
    ra    = {v.rem_a, low_a[31-k]};
    da    = {1'b0, v.d, 1'b0};
    db    = {1'b0, v.d};
    if (ra >= da) begin
      o.rem_a = 9'(ra - da);
      o.q_a   = {v.q_a[30:0], 1'b1};
    end else begin
      o.rem_a = ra[8:0];
      o.q_a   = {v.q_a[30:0], 1'b0};
    end
    rb = {v.rem_b, low_b[31-k]};
    if (rb >= db) begin
      o.rem_b = 8'(rb - db);
      o.q_b   = {v.q_b[30:0], 1'b1};
    end else begin
      o.rem_b = rb[7:0];
      o.q_b   = {v.q_b[30:0], 1'b0};
    end
    if (k < TEX_FRAC) begin
      kt = TEX_FRAC - 1 - k;
      ru = {v.rem_u, low_t[kt]};
      rv = {v.rem_v, low_t[kt]};
      if (ru >= db) begin
        o.rem_u = 8'(ru - db);
        o.q_u   = {v.q_u[14:0], 1'b1};
      end else begin
        o.rem_u = ru[7:0];
        o.q_u   = {v.q_u[14:0], 1'b0};
      end
      if (rv >= db) begin
        o.rem_v = 8'(rv - db);
        o.q_v   = {v.q_v[14:0], 1'b1};
      end else begin
        o.rem_v = rv[7:0];
        o.q_v   = {v.q_v[14:0], 1'b0};
      end
    end
    return o;
  endfunction

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= SEGMENTS_RESET;
    end else if (seg_we) begin
      segments <= seg_wdata;
    end
  end

  assign seg_eff = (32'(segments) > MAX_SEGMENTS) ? 8'(MAX_SEGMENTS) : segments;

  // pipe moves unless the last stage holds a result the output register cannot take
  assign en = !vld[NSTG-1] || !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_ch.valid;
      for (int i = 1; i < NSTG; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_row <= in_ch.row;
      r0_col <= in_ch.col;
      r0_seg <= seg_eff;
    end
  end

  // grid checks, vertex index and divider setup
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[1].oor   <= (r0_seg == 8'd0) || (r0_row > r0_seg) || (r0_col > r0_seg);
      side_q[1].pole  <= (r0_row == 8'd0) || (r0_row == r0_seg);
      side_q[1].vidx  <= 16'({8'd0, r0_row} * ({8'd0, r0_seg} + 16'd1) + {8'd0, r0_col});
      side_q[1].tex_u <= '0;
      side_q[1].tex_v <= '0;
      dv[0].d     <= r0_seg;
      dv[0].rem_a <= {1'b0, r0_row};
      dv[0].q_a   <= '0;
      dv[0].rem_b <= (r0_col == r0_seg) ? 8'd0 : r0_col;
      dv[0].q_b   <= '0;
      dv[0].rem_u <= (r0_col == r0_seg) ? 8'd0 : r0_col;
      dv[0].q_u   <= {15'd0, r0_col == r0_seg};
      dv[0].rem_v <= (r0_row == r0_seg) ? 8'd0 : r0_row;
      dv[0].q_v   <= {15'd0, r0_row == r0_seg};
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        dv[g+1] <= div_step(div_step(dv[g], DIV_PER_STAGE * g), DIV_PER_STAGE * g + 1);
      end
    end
  end

  for (genvar s = 2; s <= ST_O1; s++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        if (s == ST_T1) begin
          side_q[s].oor   <= side_q[s-1].oor;
          side_q[s].pole  <= side_q[s-1].pole;
          side_q[s].vidx  <= side_q[s-1].vidx;
          side_q[s].tex_u <= dv[DIV_STAGES].q_u;
          side_q[s].tex_v <= dv[DIV_STAGES].q_v;
        end else begin
          side_q[s] <= side_q[s-1];
        end
      end
    end
  end

  for (genvar a = 0; a < 2; a++) begin : g_ang
    logic [31:0] phase;
    logic [60:0] pt;
    logic [61:0] ptt;
    ang_t        ang_t1_next;
    ang_t        ang_t2_next;

    assign phase = (a == 0) ? dv[DIV_STAGES].q_a : dv[DIV_STAGES].q_b;
    assign pt    = 61'(phase[29:0]) * 61'(HALF_PI_Q30);
    assign ptt   = 62'(ang[ST_T1][a].t) * 62'(ang[ST_T1][a].t);

    // phase fraction to Q30 angle
    always_comb begin
      ang_t1_next      = '0;
      ang_t1_next.quad = phase[31:30];
      ang_t1_next.t    = pt[60:30];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ang[ST_T1][a] <= ang_t1_next;
      end
    end

    always_comb begin
      ang_t2_next        = ang[ST_T1][a];
      ang_t2_next.t2     = ptt[61:30];
      ang_t2_next.term_o = {1'b0, ang[ST_T1][a].t};
      ang_t2_next.term_e = 32'd1 << 30;
      ang_t2_next.acc_o  = $signed({3'b000, ang[ST_T1][a].t});
      ang_t2_next.acc_e  = 34'sh040000000;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ang[ST_T2][a] <= ang_t2_next;
      end
    end

    for (genvar j = 0; j < NTERMS; j++) begin : g_term
      localparam int SM = ST_M1 + 2 * j;
      logic [63:0] po, pe;
      logic [31:0] xo, xe;
      logic [64:0] ro, re;
      ang_t        mul_next;
      ang_t        rcp_next;

      assign po = 64'(ang[SM-1][a].term_o) * 64'(ang[SM-1][a].t2);
      assign pe = 64'(ang[SM-1][a].term_e) * 64'(ang[SM-1][a].t2);
      assign xo = 32'(ang[SM][a].pre_o >> TERM_SHIFT_ODD[j]);
      assign xe = 32'(ang[SM][a].pre_e >> TERM_SHIFT_EVEN[j]);
      assign ro = 65'(xo) * 65'(TERM_M_ODD[j]);
      assign re = 65'(xe) * 65'(TERM_M_EVEN[j]);

      // next term times t^2, and the previous term folded into the sums
      always_comb begin
        mul_next       = ang[SM-1][a];
        mul_next.pre_o = po[62:30];
        mul_next.pre_e = pe[62:30];
        if (j > 0) begin
          if (j % 2 == 1) begin
            mul_next.acc_o = ang[SM-1][a].acc_o - $signed({2'b00, ang[SM-1][a].term_o});
            mul_next.acc_e = ang[SM-1][a].acc_e - $signed({2'b00, ang[SM-1][a].term_e});
          end else begin
            mul_next.acc_o = ang[SM-1][a].acc_o + $signed({2'b00, ang[SM-1][a].term_o});
            mul_next.acc_e = ang[SM-1][a].acc_e + $signed({2'b00, ang[SM-1][a].term_e});
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ang[SM][a] <= mul_next;
        end
      end

      // exact divide by the factorial step through a reciprocal multiply
      always_comb begin
        rcp_next        = ang[SM][a];
        rcp_next.term_o = 32'(ro >> (32 + TERM_L_ODD[j]));
        rcp_next.term_e = 32'(re >> (32 + TERM_L_EVEN[j]));
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ang[SM+1][a] <= rcp_next;
        end
      end
    end

    logic signed [33:0] so, ce;
    assign so = ang[ST_F-1][a].acc_o - $signed({2'b00, ang[ST_F-1][a].term_o});
    assign ce = ang[ST_F-1][a].acc_e - $signed({2'b00, ang[ST_F-1][a].term_e});

    always_ff @(posedge clk) begin
      if (en) begin
        f_quad[a] <= ang[ST_F-1][a].quad;
        if (so < 0) begin
          f_s[a] <= '0;
        end else if (so > 34'sh040000000) begin
          f_s[a] <= 31'd1 << 30;
        end else begin
          f_s[a] <= 31'(so);
        end
        if (ce < 0) begin
          f_c[a] <= '0;
        end else if (ce > 34'sh040000000) begin
          f_c[a] <= 31'd1 << 30;
        end else begin
          f_c[a] <= 31'(ce);
        end
      end
    end

    logic signed [31:0] sv, cv;
    assign sv = $signed({1'b0, f_s[a]});
    assign cv = $signed({1'b0, f_c[a]});

    always_ff @(posedge clk) begin
      if (en) begin
        unique case (f_quad[a])
          2'd0: begin
            q_s[a] <= sv;
            q_c[a] <= cv;
          end
          2'd1: begin
            q_s[a] <= cv;
            q_c[a] <= -sv;
          end
          2'd2: begin
            q_s[a] <= -sv;
            q_c[a] <= -cv;
          end
          default: begin
            q_s[a] <= -cv;
            q_c[a] <= sv;
          end
        endcase
      end
    end
  end

  logic [30:0] m_sa, m_ca, m_sb, m_cb;
  assign m_sa = 31'(q_s[0] < 0 ? -q_s[0] : q_s[0]);
  assign m_ca = 31'(q_c[0] < 0 ? -q_c[0] : q_c[0]);
  assign m_sb = 31'(q_s[1] < 0 ? -q_s[1] : q_s[1]);
  assign m_cb = 31'(q_c[1] < 0 ? -q_c[1] : q_c[1]);

  // magnitude products with the sign kept aside
  always_ff @(posedge clk) begin
    if (en) begin
      o1_px <= 62'(m_cb) * 62'(m_sa);
      o1_nx <= (q_c[1] > 0) != (q_s[0] < 0);
      o1_pz <= 62'(m_sb) * 62'(m_sa);
      o1_nz <= (q_s[1] < 0) != (q_s[0] < 0);
      o1_py <= {1'b0, m_ca, 30'd0};
      o1_ny <= q_c[0] > 0;
    end
  end

  logic [62:0] sum_x, sum_y, sum_z;
  logic [15:0] rx, ry, rz, fx, fy, fz;
  assign sum_x = 63'(o1_px) + (63'd1 << (RSH - 1));
  assign sum_y = 63'(o1_py) + (63'd1 << (RSH - 1));
  assign sum_z = 63'(o1_pz) + (63'd1 << (RSH - 1));
  assign rx = 16'(sum_x >> RSH);
  assign ry = 16'(sum_y >> RSH);
  assign rz = 16'(sum_z >> RSH);
  assign fx = o1_nx ? 16'(16'd0 - rx) : rx;
  assign fy = o1_ny ? 16'(16'd0 - ry) : ry;
  assign fz = o1_nz ? 16'(16'd0 - rz) : rz;

  always_comb begin
    res_next = '0;
    if (side_q[ST_O1].oor) begin
      res_next.out_of_range = 1'b1;
    end else begin
      res_next.pos_x        = fx;
      res_next.pos_y        = fy;
      res_next.pos_z        = fz;
      res_next.tex_u        = side_q[ST_O1].tex_u;
      res_next.tex_v        = side_q[ST_O1].tex_v;
      res_next.tangent_x    = side_q[ST_O1].pole ? 16'd0 : fz;
      res_next.tangent_z    = side_q[ST_O1].pole ? POLE_TZ : 16'(16'd0 - fx);
      res_next.vertex_index = side_q[ST_O1].vidx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_q <= res_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (!out_vld || out_ch.ready) begin
      out_vld <= vld[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || out_ch.ready) begin
      out_q <= res_q;
    end
  end

  assign out_ch.valid        = out_vld;
  assign out_ch.pos_x        = out_q.pos_x;
  assign out_ch.pos_y        = out_q.pos_y;
  assign out_ch.pos_z        = out_q.pos_z;
  assign out_ch.tex_u        = out_q.tex_u;
  assign out_ch.tex_v        = out_q.tex_v;
  assign out_ch.tangent_x    = out_q.tangent_x;
  assign out_ch.tangent_z    = out_q.tangent_z;
  assign out_ch.vertex_index = out_q.vertex_index;
  assign out_ch.out_of_range = out_q.out_of_range;

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_q.out_of_range |->
      out_q.pos_x == 16'sd0 && out_q.pos_y == 16'sd0 && out_q.pos_z == 16'sd0 &&
      out_q.tex_u == 16'd0 && out_q.tex_v == 16'd0 && out_q.vertex_index == 16'd0 &&
      out_q.tangent_x == 16'sd0 && out_q.tangent_z == 16'sd0)
    else $error("out of range result carries nonzero fields");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_ch.ready && vld[NSTG-1] |-> !in_ch.ready)
    else $error("pipe accepted a request while its last stage was blocked");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[0])
    else $error("accepted request did not enter the pipe");

  a_tex_bound: assert property (@(posedge clk) disable iff (rst)
    out_vld && !out_q.out_of_range |-> out_q.tex_u <= 16'd32768 && out_q.tex_v <= 16'd32768)
    else $error("texture coordinate above one");

endmodule
